[rtl/spuv_pkg.sv]
// ----------------------------------------------------------------------------
// spuv_pkg
// shared constants, types and angle table of the sphere uv mapping block
// ----------------------------------------------------------------------------
`default_nettype none

package spuv_pkg;

  localparam int FRAC_BITS     = 16;
  localparam int CORDIC_STAGES = 18;

  localparam int DIV_N = 30;   // quotient bits, one per divider cell
  localparam int SQ_N  = 31;   // root bits, one per square root cell
  localparam int CW    = 60;   // cordic vector width
  localparam int AW    = 34;   // cordic angle width

  // register indexes
  typedef enum logic [1:0] {
    REG_CENTER_X = 2'd0,
    REG_CENTER_Y = 2'd1,
    REG_CENTER_Z = 2'd2,
    REG_RADIUS   = 2'd3
  } reg_idx_t;

  // payload that travels beside the arithmetic cells
  typedef struct packed {
    logic signed [32:0] dx;
    logic signed [32:0] dz;
    logic               ysign;
    logic               sat;
    logic               on;
    logic [30:0]        qm;
  } side_t;

  localparam logic [31:0] ATAN_TAB [0:31] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
    32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
    32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
    32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
    32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051, 32'h00000029,
    32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000003, 32'h00000001,
    32'h00000001, 32'h00000000
  };

endpackage

`default_nettype wire

[rtl/spuv_div_cell.sv]
// ----------------------------------------------------------------------------
// spuv_div_cell
// one restoring division step: one quotient bit per cell
// ----------------------------------------------------------------------------
`default_nettype none

module spuv_div_cell
  import spuv_pkg::*;
(
  input  wire logic              clk,
  input  wire logic [30:0]       divisor,
  input  wire logic [30:0]       rem_in,
  input  wire logic [DIV_N-1:0]  q_in,
  output logic      [30:0]       rem_out,
  output logic      [DIV_N-1:0]  q_out
);

  logic [31:0] trial;
  logic        ge;

  assign trial = {rem_in, 1'b0};
  assign ge    = trial >= {1'b0, divisor};

  always_ff @(posedge clk) begin
    rem_out <= ge ? 31'(trial - {1'b0, divisor}) : trial[30:0];
    q_out   <= {q_in[DIV_N-2:0], ge};
  end

endmodule

`default_nettype wire

[rtl/spuv_sqrt_cell.sv]
// ----------------------------------------------------------------------------
// spuv_sqrt_cell
// one digit-by-digit square root step: two radicand bits in, one root bit out
// ----------------------------------------------------------------------------
`default_nettype none

module spuv_sqrt_cell
  import spuv_pkg::*;
(
  input  wire logic              clk,
  input  wire logic [61:0]       n_in,
  input  wire logic [32:0]       rem_in,
  input  wire logic [SQ_N-1:0]   root_in,
  output logic      [61:0]       n_out,
  output logic      [32:0]       rem_out,
  output logic      [SQ_N-1:0]   root_out
);

  logic [34:0] rem2;
  logic [34:0] trial;
  logic        ge;

  assign rem2  = {rem_in, n_in[61:60]};
  assign trial = {2'b00, root_in, 2'b01};
  assign ge    = rem2 >= trial;

  always_ff @(posedge clk) begin
    n_out    <= {n_in[59:0], 2'b00};
    rem_out  <= ge ? 33'(rem2 - trial) : rem2[32:0];
    root_out <= {root_in[SQ_N-2:0], ge};
  end

endmodule

`default_nettype wire

[rtl/spuv_cordic_cell.sv]
// ----------------------------------------------------------------------------
// spuv_cordic_cell
// one vectoring cordic iteration, rotating toward y = 0
// ----------------------------------------------------------------------------
`default_nettype none

module spuv_cordic_cell
  import spuv_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic [4:0]           shift,
  input  wire logic [31:0]          angle,
  input  wire logic signed [CW-1:0] x_in,
  input  wire logic signed [CW-1:0] y_in,
  input  wire logic signed [AW-1:0] acc_in,
  output logic      signed [CW-1:0] x_out,
  output logic      signed [CW-1:0] y_out,
  output logic      signed [AW-1:0] acc_out
);

  logic signed [CW-1:0] xs;
  logic signed [CW-1:0] ys;
  logic signed [AW-1:0] da;

  assign xs = x_in >>> shift;
  assign ys = y_in >>> shift;
  assign da = $signed({2'b00, angle});

  always_ff @(posedge clk) begin
    if (!y_in[CW-1]) begin
      x_out   <= x_in + ys;
      y_out   <= y_in - xs;
      acc_out <= acc_in + da;
    end else begin
      x_out   <= x_in - ys;
      y_out   <= y_in + xs;
      acc_out <= acc_in - da;
    end
  end

endmodule

`default_nettype wire

[rtl/sphere_point_to_texture_uv.sv]
// ----------------------------------------------------------------------------
// sphere_point_to_texture_uv
// maps a point relative to a configured sphere to equirectangular uv
// ----------------------------------------------------------------------------
//  channel  | handshake         | payload
//  input    | start / busy      | point_x, point_y, point_z
//  result   | done (one cycle)  | tex_u, tex_v, on_sphere
//  config   | apb write / read  | center_x/y/z, sphere_radius
//
//  one point per cycle; busy is always low
//  the path runs through 30 divider cells, 31 square root cells and
//  18 cordic cells in series, plus setup and output stages
//  rst clears the pipeline valid bits and the registers; no clearing pass
//  results cannot be stalled and leave on done for one cycle
// ----------------------------------------------------------------------------
`default_nettype none

module sphere_point_to_texture_uv
  import spuv_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               start,
  output logic                    busy,
  input  wire logic signed [31:0] point_x,
  input  wire logic signed [31:0] point_y,
  input  wire logic signed [31:0] point_z,
  output logic                    done,
  output logic             [16:0] tex_u,
  output logic             [16:0] tex_v,
  output logic                    on_sphere,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic        [3:0]  paddr,
  input  wire logic        [31:0] pwdata,
  output logic             [31:0] prdata,
  output logic                    pready
);

  localparam int K_DIV_END = 1 + DIV_N;
  localparam int K_QM      = K_DIV_END + 1;
  localparam int K_SQ      = K_QM + 1;
  localparam int K_SQ_END  = K_SQ + SQ_N;
  localparam int K_PRE     = K_SQ_END + 1;
  localparam int K_CO_END  = K_PRE + CORDIC_STAGES;
  localparam int K_OUT     = K_CO_END + 1;

  // configuration
  logic signed [31:0] center_x;
  logic signed [31:0] center_y;
  logic signed [31:0] center_z;
  logic        [30:0] sphere_radius;
  logic        [30:0] r_eff;
  reg_idx_t           widx;
  logic               wr;

  assign pready = 1'b1;
  assign widx   = reg_idx_t'(paddr[3:2]);
  assign wr     = psel && penable && pwrite && pready;
  assign r_eff  = (sphere_radius == '0) ? 31'd1 : sphere_radius;

  always_ff @(posedge clk) begin
    if (rst) begin
      center_x      <= '0;
      center_y      <= '0;
      center_z      <= '0;
      sphere_radius <= 31'd65536;
    end else if (wr) begin
      unique case (widx)
        REG_CENTER_X: center_x      <= pwdata;
        REG_CENTER_Y: center_y      <= pwdata;
        REG_CENTER_Z: center_z      <= pwdata;
        REG_RADIUS:   sphere_radius <= pwdata[30:0];
        default:      center_x      <= center_x;
      endcase
    end
  end

  always_comb begin
    unique case (widx)
      REG_CENTER_X: prdata = center_x;
      REG_CENTER_Y: prdata = center_y;
      REG_CENTER_Z: prdata = center_z;
      REG_RADIUS:   prdata = {1'b0, sphere_radius};
      default:      prdata = '0;
    endcase
  end

  // input and valid line
  logic               accept;
  logic [K_OUT:0]     vld;

  assign busy   = 1'b0;
  assign accept = start && !busy;
  assign done   = vld[K_OUT];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[K_OUT-1:0], accept};
    end
  end

  // stage 0: differences
  logic signed [32:0] dy0;
  side_t              side [0:K_CO_END];
  side_t              side0_next;

  always_comb begin
    side0_next.dx    = $signed({point_x[31], point_x}) - $signed({center_x[31], center_x});
    side0_next.dz    = $signed({point_z[31], point_z}) - $signed({center_z[31], center_z});
    side0_next.ysign = $signed({point_y[31], point_y}) < $signed({center_y[31], center_y});
    side0_next.sat   = 1'b0;
    side0_next.on    = 1'b0;
    side0_next.qm    = '0;
  end

  always_ff @(posedge clk) begin
    dy0 <= $signed({point_y[31], point_y}) - $signed({center_y[31], center_y});
  end

  // stage 1: magnitudes and squares
  logic [32:0] mx0;
  logic [32:0] my0;
  logic [32:0] mz0;
  logic [31:0] my1;
  logic [63:0] sqx1;
  logic [63:0] sqy1;
  logic [63:0] sqz1;
  logic [61:0] r2;
  logic [65:0] sum2;
  logic [63:0] sq_gap;
  logic        on_calc;
  logic [30:0] qm_calc;
  logic [30:0] div_rem [0:DIV_N];
  logic [DIV_N-1:0] div_q [0:DIV_N];
  side_t       side1_next;
  side_t       side3_next;
  side_t       sideq_next;

  assign mx0 = side[0].dx[32] ? 33'(-side[0].dx) : side[0].dx;
  assign my0 = dy0[32] ? 33'(-dy0) : dy0;
  assign mz0 = side[0].dz[32] ? 33'(-side[0].dz) : side[0].dz;

  always_ff @(posedge clk) begin
    my1  <= my0[31:0];
    sqx1 <= mx0[31:0] * mx0[31:0];
    sqy1 <= my0[31:0] * my0[31:0];
    sqz1 <= mz0[31:0] * mz0[31:0];
    r2   <= r_eff * r_eff;
    sum2 <= 66'(sqx1) + 66'(sqy1) + 66'(sqz1);
  end

  assign sq_gap  = (sum2[63:0] >= 64'(r2)) ? sum2[63:0] - 64'(r2) : 64'(r2) - sum2[63:0];
  assign on_calc = (sum2[65:64] == 2'b00) && (sq_gap < (64'd1 << (2 * FRAC_BITS - 1)));
  assign qm_calc = side[K_DIV_END].sat ? (31'd1 << DIV_N) : {1'b0, div_q[DIV_N]};

  always_comb begin
    side1_next     = side[0];
    side1_next.sat = {1'b0, my0[31:0]} >= {2'b00, r_eff};
    side3_next     = side[2];
    side3_next.on  = on_calc;
    sideq_next     = side[K_DIV_END];
    sideq_next.qm  = qm_calc;
  end

  always_ff @(posedge clk) begin
    side[0] <= side0_next;
    for (int k = 0; k < K_CO_END; k++) begin
      if (k == 0) begin
        side[k+1] <= side1_next;
      end else if (k == 2) begin
        side[k+1] <= side3_next;
      end else if (k == K_DIV_END) begin
        side[k+1] <= sideq_next;
      end else begin
        side[k+1] <= side[k];
      end
    end
  end

  // divider chain
  assign div_rem[0] = side[1].sat ? '0 : my1[30:0];
  assign div_q[0]   = '0;

  for (genvar j = 0; j < DIV_N; j++) begin : g_div
    spuv_div_cell u_div (
      .clk     (clk),
      .divisor (r_eff),
      .rem_in  (div_rem[j]),
      .q_in    (div_q[j]),
      .rem_out (div_rem[j+1]),
      .q_out   (div_q[j+1])
    );
  end

  // square of the ratio
  logic [61:0] qsq;

  always_ff @(posedge clk) begin
    qsq <= side[K_QM].qm * side[K_QM].qm;
  end

  // square root chain
  logic [61:0]     sq_n    [0:SQ_N];
  logic [32:0]     sq_rem  [0:SQ_N];
  logic [SQ_N-1:0] sq_root [0:SQ_N];

  assign sq_n[0]    = (62'd1 << 60) - qsq;
  assign sq_rem[0]  = '0;
  assign sq_root[0] = '0;

  for (genvar j = 0; j < SQ_N; j++) begin : g_sqrt
    spuv_sqrt_cell u_sqrt (
      .clk      (clk),
      .n_in     (sq_n[j]),
      .rem_in   (sq_rem[j]),
      .root_in  (sq_root[j]),
      .n_out    (sq_n[j+1]),
      .rem_out  (sq_rem[j+1]),
      .root_out (sq_root[j+1])
    );
  end

  // cordic setup: quadrant fold for both vectors
  logic signed [CW-1:0] ax [0:CORDIC_STAGES];
  logic signed [CW-1:0] ay [0:CORDIC_STAGES];
  logic signed [AW-1:0] aa [0:CORDIC_STAGES];
  logic signed [CW-1:0] px [0:CORDIC_STAGES];
  logic signed [CW-1:0] py [0:CORDIC_STAGES];
  logic signed [AW-1:0] pa [0:CORDIC_STAGES];
  logic signed [CW-1:0] ax_pre;
  logic signed [CW-1:0] ay_pre;
  logic signed [CW-1:0] px_pre;
  logic signed [CW-1:0] py_pre;
  logic signed [31:0]   c_val;
  logic signed [AW-1:0] half_turn;

  assign half_turn = $signed(AW'(64'h8000_0000));
  assign ax_pre = $signed({{3{side[K_SQ_END].dx[32]}}, side[K_SQ_END].dx, 24'b0});
  assign ay_pre = $signed({{3{side[K_SQ_END].dz[32]}}, side[K_SQ_END].dz, 24'b0});
  assign c_val  = side[K_SQ_END].ysign ? -$signed({1'b0, side[K_SQ_END].qm})
                                       :  $signed({1'b0, side[K_SQ_END].qm});
  assign px_pre = $signed({{4{c_val[31]}}, c_val, 24'b0});
  assign py_pre = $signed({5'b0, sq_root[SQ_N], 24'b0});

  always_ff @(posedge clk) begin
    if (ax_pre[CW-1]) begin
      ax[0] <= -ax_pre;
      ay[0] <= -ay_pre;
      aa[0] <= ay_pre[CW-1] ? -half_turn : half_turn;
    end else begin
      ax[0] <= ax_pre;
      ay[0] <= ay_pre;
      aa[0] <= '0;
    end
    if (px_pre[CW-1]) begin
      px[0] <= -px_pre;
      py[0] <= -py_pre;
      pa[0] <= py_pre[CW-1] ? -half_turn : half_turn;
    end else begin
      px[0] <= px_pre;
      py[0] <= py_pre;
      pa[0] <= '0;
    end
  end

  for (genvar j = 0; j < CORDIC_STAGES; j++) begin : g_cordic
    spuv_cordic_cell u_azim (
      .clk     (clk),
      .shift   (5'(j)),
      .angle   (ATAN_TAB[j]),
      .x_in    (ax[j]),
      .y_in    (ay[j]),
      .acc_in  (aa[j]),
      .x_out   (ax[j+1]),
      .y_out   (ay[j+1]),
      .acc_out (aa[j+1])
    );
    spuv_cordic_cell u_polar (
      .clk     (clk),
      .shift   (5'(j)),
      .angle   (ATAN_TAB[j]),
      .x_in    (px[j]),
      .y_in    (py[j]),
      .acc_in  (pa[j]),
      .x_out   (px[j+1]),
      .y_out   (py[j+1]),
      .acc_out (pa[j+1])
    );
  end

  // output scaling
  logic                 a_zero;
  logic signed [AW-1:0] a_ang;
  logic signed [35:0]   t_u;
  logic        [16:0]   u_calc;
  logic        [31:0]   v_ang;
  logic        [32:0]   v_rnd;
  logic        [17:0]   v_calc;

  assign a_zero = (side[K_CO_END].dx == '0) && (side[K_CO_END].dz == '0);
  assign a_ang  = a_zero ? '0 : aa[CORDIC_STAGES];
  assign t_u    = $signed({{(36-AW){a_ang[AW-1]}}, a_ang}) + 36'sd2147516416;

  always_comb begin
    if (t_u[35]) begin
      u_calc = '0;
    end else if (t_u[34:16] > 19'd65536) begin
      u_calc = 17'd65536;
    end else begin
      u_calc = t_u[32:16];
    end
    if (pa[CORDIC_STAGES][AW-1]) begin
      v_ang = '0;
    end else if (pa[CORDIC_STAGES] > half_turn) begin
      v_ang = 32'h8000_0000;
    end else begin
      v_ang = pa[CORDIC_STAGES][31:0];
    end
  end

  assign v_rnd  = 33'(v_ang) + 33'd16384;
  assign v_calc = 18'd65536 - v_rnd[32:15];

  always_ff @(posedge clk) begin
    tex_u     <= u_calc;
    tex_v     <= v_calc[16:0];
    on_sphere <= side[K_CO_END].on;
  end

  // checks
  a_busy_low: assert property (@(posedge clk) !busy)
    else $error("busy raised");
  a_u_range: assert property (@(posedge clk) disable iff (rst) done |-> tex_u <= 17'd65536)
    else $error("tex_u out of range");
  a_v_range: assert property (@(posedge clk) disable iff (rst) done |-> tex_v <= 17'd65536)
    else $error("tex_v out of range");
  a_reset_quiet: assert property (@(posedge clk) rst |=> !done)
    else $error("word after reset");

endmodule

`default_nettype wire

[sim/testbench.sv]
// ----------------------------------------------------------------------------
// testbench
// checks sphere point to uv mapping against a bit exact cordic predictor,
// with random start gaps, apb register phases and a drain pause
// ----------------------------------------------------------------------------
`default_nettype none

module testbench;
  import spuv_pkg::*;

  typedef struct packed {
    logic signed [31:0] px;
    logic signed [31:0] py;
    logic signed [31:0] pz;
  } point_t;

  typedef struct packed {
    logic [16:0] u;
    logic [16:0] v;
    logic        on;
  } uv_t;

  localparam int LATENCY   = 85;
  localparam int WDOG_MAX  = 2000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic signed [31:0] point_x = '0, point_y = '0, point_z = '0;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [3:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic busy, done, on_sphere, pready;
  logic [16:0] tex_u, tex_v;
  logic [31:0] prdata;

  logic signed [31:0] m_cx = 0, m_cy = 0, m_cz = 0;
  logic [30:0] m_rad = 31'd65536;

  point_t point_q[$];
  uv_t    uv_q[$];
  int     errors = 0;
  int     wdog = 0;
  bit     quiet = 1'b0;
  bit     hold = 1'b1;
  int     gap = 0;

  sphere_point_to_texture_uv i_dut (
    .clk, .rst, .start, .busy, .point_x, .point_y, .point_z,
    .done, .tex_u, .tex_v, .on_sphere,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  always #6 clk = ~clk;

  function automatic logic signed [63:0] sra64(logic signed [63:0] a, int s);
    return a >>> s;
  endfunction

  function automatic logic signed [63:0] azimuth(logic signed [63:0] y,
                                                 logic signed [63:0] x);
    logic signed [63:0] acc, xs, ys;
    acc = 0;
    if (x == 0 && y == 0) return 0;
    x = x <<< 24;
    y = y <<< 24;
    if (x < 0) begin
      acc = (y >= 0) ? 64'sh80000000 : -64'sh80000000;
      x = -x;
      y = -y;
    end
    for (int i = 0; i < CORDIC_STAGES; i++) begin
      xs = sra64(x, i);
      ys = sra64(y, i);
      if (y >= 0) begin
        x += ys; y -= xs; acc += $signed({32'd0, ATAN_TAB[i]});
      end else begin
        x -= ys; y += xs; acc -= $signed({32'd0, ATAN_TAB[i]});
      end
    end
    return acc;
  endfunction

  function automatic logic [63:0] root64(logic [63:0] n);
    logic [63:0] res, b;
    res = 0;
    b = 64'd1 << 62;
    while (b > n) b >>= 2;
    while (b != 0) begin
      if (n >= res + b) begin
        n -= res + b;
        res = (res >> 1) + b;
      end else begin
        res >>= 1;
      end
      b >>= 2;
    end
    return res;
  endfunction

  function automatic uv_t map_point(point_t p);
    logic signed [63:0] dx, dy, dz, ang, t, c;
    logic [127:0] sq, r2;
    logic [63:0] r, qm, s, m;
    uv_t o;
    dx = 64'(p.px) - 64'(m_cx);
    dy = 64'(p.py) - 64'(m_cy);
    dz = 64'(p.pz) - 64'(m_cz);
    r = (m_rad == 0) ? 64'd1 : 64'(m_rad);
    sq = 128'(dx) * 128'(dx) + 128'(dy) * 128'(dy) + 128'(dz) * 128'(dz);
    r2 = 128'(r) * 128'(r);
    if (sq >= r2) o.on = (sq - r2) < (128'd1 << (2 * FRAC_BITS - 1));
    else o.on = (r2 - sq) < (128'd1 << (2 * FRAC_BITS - 1));
    ang = azimuth(dz, dx);
    t = ang + 64'sh80000000 + 32768;
    if (t < 0) o.u = 0;
    else o.u = (t >>> 16) > 65536 ? 17'd65536 : 17'(t >>> 16);
    m = dy < 0 ? 64'(-dy) : 64'(dy);
    qm = (m << 30) / r;
    if (qm > (64'd1 << 30)) qm = 64'd1 << 30;
    c = dy < 0 ? -$signed(qm) : $signed(qm);
    s = root64((64'd1 << 60) - qm * qm);
    ang = azimuth($signed(s), c);
    if (ang < 0) ang = 0;
    if (ang > 64'sh80000000) ang = 64'sh80000000;
    o.v = 17'(65536 - ((ang + 16384) >>> 15));
    return o;
  endfunction

  // driver
  always @(posedge clk) begin
    if (rst || hold) begin
      start <= 1'b0;
    end else if (start && busy) begin
    end else if (gap > 0) begin
      start <= 1'b0;
      gap <= gap - 1;
    end else if (point_q.size() > 0) begin
      start <= 1'b1;
      {point_x, point_y, point_z} <= point_q[0];
      uv_q.push_back(map_point(point_q[0]));
      void'(point_q.pop_front());
      if (!quiet && $urandom_range(0, 7) == 0) gap <= $urandom_range(1, 5);
    end else begin
      start <= 1'b0;
    end
  end

  // monitor and watchdog
  always @(posedge clk) begin
    uv_t e;
    if (!rst) begin
      if ((start && !busy) || done) wdog <= 0;
      else wdog <= wdog + 1;
      if (wdog > WDOG_MAX) begin
        $display("Test completed with failures");
        $finish;
      end
      if (done) begin
        if (uv_q.size() == 0) begin
          $display("%0t unexpected word u=%0d v=%0d on=%0d", $time, tex_u, tex_v,
                   on_sphere);
          errors++;
        end else begin
          e = uv_q.pop_front();
          if (e.u !== tex_u) begin
            $display("%0t tex_u expected %0d actual %0d", $time, e.u, tex_u);
            errors++;
          end
          if (e.v !== tex_v) begin
            $display("%0t tex_v expected %0d actual %0d", $time, e.v, tex_v);
            errors++;
          end
          if (e.on !== on_sphere) begin
            $display("%0t on_sphere expected %0d actual %0d", $time, e.on,
                     on_sphere);
            errors++;
          end
        end
      end
    end
  end

  task automatic reg_write(reg_idx_t idx, logic [31:0] val);
    @(posedge clk);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= 4'(idx) << 2; pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    case (idx)
      REG_CENTER_X: m_cx = val;
      REG_CENTER_Y: m_cy = val;
      REG_CENTER_Z: m_cz = val;
      default:      m_rad = val[30:0];
    endcase
  endtask

  task automatic drain();
    while (point_q.size() > 0 || uv_q.size() > 0 || start) @(posedge clk);
    hold = 1'b1;
    repeat (LATENCY + 5) @(posedge clk);
  endtask

  function automatic logic [31:0] rnd_coord(int mode);
    case (mode)
      0: return $urandom();
      1: return $signed($urandom_range(0, 262143)) - 131072;
      2: return 32'h80000000 + $urandom_range(0, 3);
      default: return 32'h7FFFFFFF - $urandom_range(0, 3);
    endcase
  endfunction

  function automatic point_t near_point();
    real th, ph, rr;
    point_t p;
    th = $urandom_range(0, 62831) / 10000.0;
    ph = $urandom_range(0, 31415) / 10000.0;
    rr = real'(m_rad);
    p.px = m_cx + 32'($rtoi(rr * $sin(ph) * $cos(th)));
    p.py = m_cy + 32'($rtoi(rr * $cos(ph)));
    p.pz = m_cz + 32'($rtoi(rr * $sin(ph) * $sin(th)));
    return p;
  endfunction

  task automatic add_random(int n);
    point_t p;
    for (int k = 0; k < n; k++) begin
      case ($urandom_range(0, 3))
        0, 1: p = near_point();
        2: p = {rnd_coord(1), rnd_coord(1), rnd_coord(1)};
        default: p = {rnd_coord($urandom_range(0, 3)), rnd_coord($urandom_range(0, 3)),
                      rnd_coord($urandom_range(0, 3))};
      endcase
      point_q.push_back(p);
    end
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    repeat (2) @(posedge clk);
    // directed: axes, poles, centre, extremes
    point_q.push_back({32'sd0, 32'sd0, 32'sd0});
    point_q.push_back({32'sd65536, 32'sd0, 32'sd0});
    point_q.push_back({-32'sd65536, 32'sd0, 32'sd0});
    point_q.push_back({32'sd0, 32'sd0, 32'sd65536});
    point_q.push_back({32'sd0, 32'sd0, -32'sd65536});
    point_q.push_back({-32'sd65536, 32'sd0, -32'sd1});
    point_q.push_back({32'sd0, 32'sd65536, 32'sd0});
    point_q.push_back({32'sd0, -32'sd65536, 32'sd0});
    point_q.push_back({32'sd0, 32'sd40000, 32'sd0});
    point_q.push_back({32'sd46341, 32'sd0, 32'sd46341});
    point_q.push_back({32'h80000000, 32'h80000000, 32'h80000000});
    point_q.push_back({32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF});
    point_q.push_back({32'h80000000, 32'h7FFFFFFF, 32'h7FFFFFFF});
    point_q.push_back({32'hFFFFFFFF, 32'h00000001, 32'hFFFFFFFF});
    hold = 1'b0;
    drain();
    // zero radius, extreme centres
    reg_write(REG_RADIUS, 32'd0);
    reg_write(REG_CENTER_X, 32'h7FFFFFFF);
    reg_write(REG_CENTER_Y, 32'h80000000);
    reg_write(REG_CENTER_Z, 32'h80000000);
    point_q.push_back({32'h80000000, 32'h7FFFFFFF, 32'h7FFFFFFF});
    point_q.push_back({32'h7FFFFFFF, 32'h80000000, 32'h80000000});
    point_q.push_back({32'h7FFFFFFF, 32'h80000001, 32'h80000000});
    add_random(150);
    hold = 1'b0;
    drain();
    reg_write(REG_RADIUS, 32'h7FFFFFFF);
    reg_write(REG_CENTER_X, 32'd0);
    reg_write(REG_CENTER_Y, 32'd0);
    reg_write(REG_CENTER_Z, 32'd0);
    add_random(300);
    hold = 1'b0;
    drain();
    for (int ph = 0; ph < 4; ph++) begin
      reg_write(REG_CENTER_X, $urandom());
      reg_write(REG_CENTER_Y, $signed($urandom_range(0, 1 << 20)) - (1 << 19));
      reg_write(REG_CENTER_Z, $urandom());
      reg_write(REG_RADIUS, $urandom_range(1, 1 << 22));
      add_random(300);
      if (ph == 3) quiet = 1'b1;
      hold = 1'b0;
      drain();
    end
    reg_write(REG_RADIUS, 32'd1);
    add_random(180);
    hold = 1'b0;
    drain();
    if (errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

`default_nettype wire
